FILE: design/spfe_pkg.sv
// Shared types and constants for the spanning forest edge union unit.
// No dependencies; imported by every module of the block.
package spfe_pkg;

  localparam int NODE_W   = 10;   // node index width on the input channel
  localparam int LABEL_W  = 10;   // tree label width (labels wrap)
  localparam int COUNT_W  = 10;   // accepted edge counter width
  localparam int TREE_W   = 9;    // tree_id width on the result channel
  localparam int STATUS_W = 3;
  localparam int NCOUNT_W = 11;   // node_count register width
  localparam int LIMIT_W  = 10;   // edge_limit register width
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_NODES = 1024;

  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = 11'd1024;
  localparam logic [LIMIT_W-1:0]  EDGE_LIMIT_RST = 10'd1023;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_EDGE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_LIMIT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW   = 3'd0,
    ST_JOIN  = 3'd1,
    ST_MERGE = 3'd2,
    ST_CYCLE = 3'd3,
    ST_LIMIT = 3'd4,
    ST_BAD   = 3'd5,
    ST_CLEAR = 3'd6
  } status_t;

  typedef struct packed {
    logic               valid;
    logic [LABEL_W-1:0] label;
  } entry_t;

  typedef struct packed {
    status_t             status;
    logic [COUNT_W-1:0]  edge_count;
    logic [TREE_W-1:0]   tree_id;
    logic                limit_reached;
  } result_t;

endpackage

FILE: design/spfe_label_mem.sv
// Label store: one write port, two registered read ports.
// Depends on spfe_pkg for the entry type.
module spfe_label_mem
  import spfe_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_NODES,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr0,
  output entry_t        rd_data0,
  input  logic [AW-1:0] rd_addr1,
  output entry_t        rd_data1
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

FILE: design/spfe_seq.sv
// Sequencer: clear sweep, label lookup, union decision and relabel scan.
// Depends on spfe_pkg; drives the ports of spfe_label_mem.
module spfe_seq
  import spfe_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES,
  localparam int AW = $clog2(MAX_NODES),
  localparam int NW = $clog2(MAX_NODES + 1),
  localparam int CW = (NW > NODE_W) ? NW : NODE_W
) (
  input  logic               clk,
  input  logic               rst,
  // input transaction
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [NODE_W-1:0]  node_a,
  input  logic [NODE_W-1:0]  node_b,
  // effective configuration
  input  logic [NW-1:0]      eff_nodes,
  input  logic [COUNT_W-1:0] eff_limit,
  // result handoff
  output logic               res_valid,
  input  logic               res_take,
  output result_t            res,
  // label store
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output entry_t             wr_data,
  output logic [AW-1:0]      rd_addr0,
  input  entry_t             rd_data0,
  output logic [AW-1:0]      rd_addr1,
  input  entry_t             rd_data1
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_EVAL, S_WRB, S_SCAN, S_SCAN_END, S_DONE
  } state_t;

  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);

  state_t              state;
  logic [AW-1:0]       ctr;
  logic [AW-1:0]       scan_addr;
  logic                scan_pend;
  logic                clear_cmd;
  logic [NODE_W-1:0]   a_reg;
  logic [NODE_W-1:0]   b_reg;
  logic [LABEL_W-1:0]  la_reg;
  logic [LABEL_W-1:0]  lb_reg;
  logic [LABEL_W-1:0]  tree_reg;
  logic [LABEL_W-1:0]  next_tree;
  logic [COUNT_W-1:0]  acc;
  status_t             status_reg;

  logic                accept;
  logic                bad_node;
  logic                lab_eq;
  logic                scan_hit;
  status_t             ev_status;
  logic [LABEL_W-1:0]  ev_tree;
  logic                ev_write;
  logic [AW-1:0]       ev_waddr;
  logic [LABEL_W-1:0]  ev_wlabel;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign bad_node = (CW'(node_a) >= CW'(eff_nodes)) || (CW'(node_b) >= CW'(eff_nodes));

  // shared label comparator: edge evaluation and relabel scan
  always_comb begin
    if (state == S_EVAL) begin
      lab_eq = (rd_data0.label == rd_data1.label);
    end else begin
      lab_eq = (rd_data0.label == lb_reg);
    end
  end
  assign scan_hit = scan_pend && rd_data0.valid && lab_eq;

  // union decision on the two fetched labels
  always_comb begin
    ev_status = ST_CYCLE;
    ev_tree   = '0;
    ev_write  = 1'b0;
    ev_waddr  = AW'(a_reg);
    ev_wlabel = rd_data0.label;
    priority if (acc >= eff_limit) begin
      ev_status = ST_LIMIT;
      ev_tree   = rd_data0.valid ? rd_data0.label : '0;
    end else if (a_reg == b_reg) begin
      ev_status = ST_CYCLE;
      ev_tree   = rd_data0.valid ? rd_data0.label : '0;
    end else if (!rd_data0.valid && !rd_data1.valid) begin
      ev_status = ST_NEW;
      ev_tree   = next_tree;
      ev_write  = 1'b1;
      ev_wlabel = next_tree;
    end else if (!rd_data0.valid || !rd_data1.valid) begin
      ev_status = ST_JOIN;
      ev_write  = 1'b1;
      if (rd_data0.valid) begin
        ev_tree  = rd_data0.label;
        ev_waddr = AW'(b_reg);
      end else begin
        ev_tree  = rd_data1.label;
        ev_waddr = AW'(a_reg);
      end
      ev_wlabel = ev_tree;
    end else if (!lab_eq) begin
      ev_status = ST_MERGE;
      ev_tree   = rd_data0.label;
    end else begin
      ev_status = ST_CYCLE;
      ev_tree   = rd_data0.label;
    end
  end

  // label store control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ctr;
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_EVAL: begin
        wr_en   = ev_write;
        wr_addr = ev_waddr;
        wr_data = '{valid: 1'b1, label: ev_wlabel};
      end
      S_WRB: begin
        wr_en   = 1'b1;
        wr_addr = AW'(b_reg);
        wr_data = '{valid: 1'b1, label: la_reg};
      end
      S_SCAN, S_SCAN_END: begin
        wr_en   = scan_hit;
        wr_addr = scan_addr;
        wr_data = '{valid: 1'b1, label: la_reg};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign rd_addr0 = (state == S_SCAN) ? ctr : AW'(a_reg);
  assign rd_addr1 = AW'(b_reg);

  assign res_valid         = (state == S_DONE);
  assign res.status        = status_reg;
  assign res.edge_count    = acc;
  assign res.tree_id       = tree_reg[TREE_W-1:0];
  assign res.limit_reached = (acc >= eff_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ctr       <= '0;
      scan_pend <= 1'b0;
      clear_cmd <= 1'b0;
      next_tree <= '0;
      acc       <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (ctr == LAST_ADDR) begin
            ctr   <= '0;
            state <= clear_cmd ? S_DONE : S_IDLE;
          end else begin
            ctr <= ctr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            a_reg <= node_a;
            b_reg <= node_b;
            if (command == CMD_CLEAR) begin
              clear_cmd  <= 1'b1;
              next_tree  <= '0;
              acc        <= '0;
              status_reg <= ST_CLEAR;
              tree_reg   <= '0;
              ctr        <= '0;
              state      <= S_CLEAR;
            end else if (bad_node) begin
              status_reg <= ST_BAD;
              tree_reg   <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          status_reg <= ev_status;
          tree_reg   <= ev_tree;
          la_reg     <= rd_data0.label;
          lb_reg     <= rd_data1.label;
          scan_pend  <= 1'b0;
          ctr        <= '0;
          unique case (ev_status)
            ST_NEW: begin
              la_reg    <= next_tree;
              next_tree <= next_tree + 1'b1;
              acc       <= acc + 1'b1;
              state     <= S_WRB;
            end
            ST_JOIN: begin
              acc   <= acc + 1'b1;
              state <= S_DONE;
            end
            ST_MERGE: begin
              acc   <= acc + 1'b1;
              state <= S_SCAN;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_WRB: begin
          state <= S_DONE;
        end
        S_SCAN: begin
          scan_pend <= 1'b1;
          scan_addr <= ctr;
          if (ctr == LAST_ADDR) begin
            state <= S_SCAN_END;
          end else begin
            ctr <= ctr + 1'b1;
          end
        end
        S_SCAN_END: begin
          scan_pend <= 1'b0;
          ctr       <= '0;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            clear_cmd <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/spanning_forest_edge_union_unit.sv
// Flow: an accepted edge offer passes S_READ and S_EVAL to S_DONE; a new tree adds S_WRB,
// a merge adds a relabel scan of the store, and a bad node goes straight to S_DONE; a
// clear sweeps the whole store. Throughput: one transaction at a time; in_stall is high
// until the result reaches the output register; merges and clears are the long cases.
// Reset: synchronous; control and config registers return to reset values and a
// clearing pass over every address empties the label store with in_stall high.
module spanning_forest_edge_union_unit
  import spfe_pkg::*;
#(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NCOUNT_W-1:0]  cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 command,
  input  logic [NODE_W-1:0]    node_a,
  input  logic [NODE_W-1:0]    node_b,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [COUNT_W-1:0]   edge_count,
  output logic [TREE_W-1:0]    tree_id,
  output logic                 limit_reached
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int CW = (NW > NCOUNT_W) ? NW : NCOUNT_W;

  logic [NCOUNT_W-1:0] node_count;
  logic [LIMIT_W-1:0]  edge_limit;
  logic [CW-1:0]       nodes_wide;
  logic [NW-1:0]       eff_nodes;
  logic [NW-1:0]       node_cap;
  logic [COUNT_W-1:0]  eff_limit;

  logic    res_valid;
  logic    res_take;
  result_t res;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic [AW-1:0] rd_addr0;
  logic [AW-1:0] rd_addr1;
  entry_t        rd_data0;
  entry_t        rd_data1;

  // Configuration writes are always taken; an index off the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
      edge_limit <= EDGE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NODE_COUNT: node_count <= cfg_data;
        REG_EDGE_LIMIT: edge_limit <= cfg_data[LIMIT_W-1:0];
        default: begin
          node_count <= node_count;
        end
      endcase
    end
  end

  // Clamp node_count to 2..MAX_NODES, then the limit to node count minus one.
  always_comb begin
    nodes_wide = CW'(node_count);
    if (nodes_wide < CW'(2)) begin
      nodes_wide = CW'(2);
    end else if (nodes_wide > CW'(MAX_NODES)) begin
      nodes_wide = CW'(MAX_NODES);
    end
  end
  assign eff_nodes = NW'(nodes_wide);
  assign node_cap  = eff_nodes - 1'b1;
  assign eff_limit = (CW'(edge_limit) < CW'(node_cap)) ? edge_limit : COUNT_W'(node_cap);

  spfe_seq #(
    .MAX_NODES(MAX_NODES)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .node_a    (node_a),
    .node_b    (node_b),
    .eff_nodes (eff_nodes),
    .eff_limit (eff_limit),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr0  (rd_addr0),
    .rd_data0  (rd_data0),
    .rd_addr1  (rd_addr1),
    .rd_data1  (rd_data1)
  );

  spfe_label_mem #(
    .DEPTH(MAX_NODES)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr0 (rd_addr0),
    .rd_data0 (rd_data0),
    .rd_addr1 (rd_addr1),
    .rd_data1 (rd_data1)
  );

  // Output register: load a finished result whenever the slot is empty or
  // its transaction completes this cycle; hold while stalled.
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      status        <= res.status;
      edge_count    <= res.edge_count;
      tree_id       <= res.tree_id;
      limit_reached <= res.limit_reached;
    end
  end

endmodule

FILE: design/spfe_checker.sv
// Port-level checker for the spanning forest edge union unit, with its bind.
// Depends on spfe_pkg for status codes and field widths.
module spfe_checker
  import spfe_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] status,
  input logic [COUNT_W-1:0]  edge_count,
  input logic [TREE_W-1:0]   tree_id
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(edge_count)
      && $stable(tree_id))
    else $error("stalled result changed");

  // a clear leaves an empty forest behind
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_CLEAR) |-> (edge_count == '0) && (tree_id == '0))
    else $error("clear result not empty");

  // bad node reports no tree
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_BAD) |-> (tree_id == '0))
    else $error("bad node result carries a tree");

  // right after reset the block stalls input and shows no result, as the store sweep begins
  assert property (@(posedge clk)
    rst |=> in_stall && !out_valid)
    else $error("input taken or result shown right after reset");

endmodule

bind spanning_forest_edge_union_unit spfe_checker u_spfe_checker (.*);
